/* hw/rtl/hsv2rgb_pkg.sv */
// shared types and constants for the hsv to rgb converter pipeline
// no dependencies; imported by hsv2rgb_div10k and hsv_to_rgb_converter
`default_nettype none

package hsv2rgb_pkg;

  // input and output field widths
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CHAN_W = 8;

  // limits
  localparam int HUE_LIMIT = 360;
  localparam int PCT_MAX = 100;
  localparam int CHANNEL_MAX = 255;
  localparam int SECTOR_DEG = 60;
  localparam int TWO_SECTORS = 2 * SECTOR_DEG;

  // register stages of the converter pipeline
  localparam int STAGES = 9;

  // internal widths
  localparam int K_W = 6;       // distance from sector edge, 0..60
  localparam int FRAC_W = 14;   // fractions and products on the 0..10000 scale
  localparam int NUM_W = 27;    // dividend of the divide-by-10000 unit

  // sector fraction f = 500*k/3 = 166*k + floor(2*k/3)
  localparam int F_WHOLE = 166;
  localparam int THIRD_MUL = 171;   // floor(n/3) = (n*171) >> 9 for n < 256
  localparam int THIRD_SHIFT = 9;
  localparam int THIRD_PROD_W = 15;

  // divide by 10000 as (num >> 4) / 625 with reciprocal estimate and one fix
  localparam int DIV_PRE_SHIFT = 4;
  localparam int DIV_N_W = NUM_W - DIV_PRE_SHIFT;
  localparam int DIV_D = 625;
  localparam int RECIP_W = 23;
  localparam int RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP = 23'd6871947;  // floor(2^32 / 625)
  localparam int QUO_W = 14;

  // 60-degree sectors of the hue wheel
  localparam logic [2:0] SECT_0 = 3'd0;
  localparam logic [2:0] SECT_1 = 3'd1;
  localparam logic [2:0] SECT_2 = 3'd2;
  localparam logic [2:0] SECT_3 = 3'd3;
  localparam logic [2:0] SECT_4 = 3'd4;
  localparam logic [2:0] SECT_5 = 3'd5;

  // load enables of the two divider stages
  typedef struct packed {
    logic est;
    logic fix;
  } div_en_t;

endpackage

`default_nettype wire

/* hw/rtl/hsv_to_rgb_converter.sv */
// Integer HSV to RGB converter.
// Input channel in_valid/in_ready carries one item: hue in degrees (0..359),
// saturation and value in percent (values above 100 are clamped to 100).
// Output channel out_valid/out_ready returns one item per input item: 8-bit
// red, green, blue and a flag that is set, with all colours zero, when the
// hue is 360 or more.
// The result passes through a nine-stage register pipeline (sector and
// clamp, chroma and fraction, product, two divide-by-10000 steps,
// mid-channel numerator, two more divide steps, and the channel select in
// the output register).
// Throughput: one item per cycle while out_ready is high; every stage
// loads when it is empty or when the stage after it moves, so empty
// stages fill even while the output waits.
// When out_ready is low the output holds its item and the pipeline fills;
// in_ready falls only when every stage holds an item.
// Synchronous active-low reset empties the pipeline; no item is in flight
// afterwards and in_ready is high in the following cycle.
// depends on hsv2rgb_pkg and hsv2rgb_div10k
`default_nettype none

module hsv_to_rgb_converter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]    in_hue,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]    in_saturation,
  input  logic [hsv2rgb_pkg::PCT_W-1:0]    in_brightness,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]   out_red,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]   out_green,
  output logic [hsv2rgb_pkg::CHAN_W-1:0]   out_blue,
  output logic                             out_hue_out_of_range
);
  import hsv2rgb_pkg::*;

  // pipeline control
  logic [STAGES:1] vld_r;
  logic [STAGES:1] vld_nxt;
  logic [STAGES:1] en;

  // per-stage payload
  logic [2:0]        sect_r [1:8];
  logic              flag_r [1:8];
  logic [K_W-1:0]    k_r;
  logic [PCT_W-1:0]  s_r;
  logic [PCT_W-1:0]  v_r;
  logic [FRAC_W-1:0] c_r;
  logic [FRAC_W-1:0] f_r;
  logic [FRAC_W-1:0] v100_r;
  logic [NUM_W-1:0]  xnum_r;
  logic [NUM_W-1:0]  hnum_r;
  logic [FRAC_W-1:0] m3_r;
  logic [FRAC_W-1:0] m4_r;
  logic [FRAC_W-1:0] m5_r;
  logic [NUM_W-1:0]  mnum_r;
  logic [CHAN_W-1:0] hi6_r;
  logic [CHAN_W-1:0] hi7_r;
  logic [CHAN_W-1:0] hi8_r;
  logic [CHAN_W-1:0] red_r;
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;
  logic              flag9_r;

  // stage 1 combinational
  logic              flag_nxt;
  logic [2:0]        sect_nxt;
  logic [HUE_W-1:0]  hm;
  logic [HUE_W-1:0]  hue_off;
  logic [K_W-1:0]    k_nxt;
  logic [PCT_W-1:0]  s_nxt;
  logic [PCT_W-1:0]  v_nxt;

  // stage 2 and later combinational
  logic [THIRD_PROD_W-1:0] third_prod;
  logic [FRAC_W-1:0]       f_nxt;
  logic [2*FRAC_W-1:0]     xprod;
  logic [QUO_W-1:0]        x_quo;
  logic [QUO_W-1:0]        hi_quo;
  logic [QUO_W-1:0]        mid_quo;
  logic [FRAC_W-1:0]       xm_sum;
  logic [CHAN_W-1:0]       mid;
  logic [CHAN_W-1:0]       hi;
  logic [CHAN_W-1:0]       red_nxt;
  logic [CHAN_W-1:0]       green_nxt;
  logic [CHAN_W-1:0]       blue_nxt;

  // a stage loads when it is empty or its item moves on
  always_comb begin
    en[STAGES] = !vld_r[STAGES] || out_ready;
    for (int i = STAGES - 1; i >= 1; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready = en[1];

  always_comb begin
    vld_nxt = vld_r;
    if (en[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int i = 2; i <= STAGES; i++) begin
      if (en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: range flag, sector, distance from sector edge, clamps
  assign flag_nxt = in_hue >= HUE_W'(HUE_LIMIT);

  always_comb begin
    if (in_hue < HUE_W'(SECTOR_DEG))            sect_nxt = SECT_0;
    else if (in_hue < HUE_W'(2 * SECTOR_DEG))   sect_nxt = SECT_1;
    else if (in_hue < HUE_W'(3 * SECTOR_DEG))   sect_nxt = SECT_2;
    else if (in_hue < HUE_W'(4 * SECTOR_DEG))   sect_nxt = SECT_3;
    else if (in_hue < HUE_W'(5 * SECTOR_DEG))   sect_nxt = SECT_4;
    else                                        sect_nxt = SECT_5;
  end

  always_comb begin
    if (in_hue >= HUE_W'(2 * TWO_SECTORS))      hm = in_hue - HUE_W'(2 * TWO_SECTORS);
    else if (in_hue >= HUE_W'(TWO_SECTORS))     hm = in_hue - HUE_W'(TWO_SECTORS);
    else                                        hm = in_hue;
    hue_off = (hm >= HUE_W'(SECTOR_DEG)) ? hm - HUE_W'(SECTOR_DEG) : HUE_W'(SECTOR_DEG) - hm;
    k_nxt   = K_W'(HUE_W'(SECTOR_DEG) - hue_off);
  end

  assign s_nxt = (in_saturation > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_saturation;
  assign v_nxt = (in_brightness > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_brightness;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sect_r[1] <= sect_nxt;
      flag_r[1] <= flag_nxt;
      k_r       <= k_nxt;
      s_r       <= s_nxt;
      v_r       <= v_nxt;
    end
  end

  // side-band sector and flag travel with the item
  always_ff @(posedge clk) begin
    for (int i = 2; i <= 8; i++) begin
      if (en[i]) begin
        sect_r[i] <= sect_r[i-1];
        flag_r[i] <= flag_r[i-1];
      end
    end
  end

  // stage 2: chroma c = s*v, fraction f = 500*k/3, v scaled by 100
  assign third_prod = THIRD_PROD_W'({k_r, 1'b0}) * THIRD_PROD_W'(THIRD_MUL);
  assign f_nxt = FRAC_W'(k_r) * FRAC_W'(F_WHOLE)
               + FRAC_W'(third_prod >> THIRD_SHIFT);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_r    <= FRAC_W'(s_r) * FRAC_W'(v_r);
      f_r    <= f_nxt;
      v100_r <= FRAC_W'(v_r) * FRAC_W'(PCT_MAX);
    end
  end

  // stage 3: c*f, offset m, numerator of the full channel
  assign xprod = (2*FRAC_W)'(c_r) * (2*FRAC_W)'(f_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      xnum_r <= xprod[NUM_W-1:0];
      hnum_r <= NUM_W'(v100_r) * NUM_W'(CHANNEL_MAX);
      m3_r   <= v100_r - c_r;
    end
  end

  // stages 4 and 5: x = c*f/10000 and the full channel level
  hsv2rgb_div10k u_div_x (
    .clk (clk),
    .en  ('{est: en[4], fix: en[5]}),
    .num (xnum_r),
    .quo (x_quo)
  );

  hsv2rgb_div10k u_div_hi (
    .clk (clk),
    .en  ('{est: en[4], fix: en[5]}),
    .num (hnum_r),
    .quo (hi_quo)
  );

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m4_r <= m3_r;
    end
    if (en[5]) begin
      m5_r <= m4_r;
    end
  end

  // stage 6: numerator of the mid channel
  assign xm_sum = x_quo + m5_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mnum_r <= NUM_W'(xm_sum) * NUM_W'(CHANNEL_MAX);
      hi6_r  <= hi_quo[CHAN_W-1:0];
    end
  end

  // stages 7 and 8: mid channel level
  hsv2rgb_div10k u_div_mid (
    .clk (clk),
    .en  ('{est: en[7], fix: en[8]}),
    .num (mnum_r),
    .quo (mid_quo)
  );

  always_ff @(posedge clk) begin
    if (en[7]) begin
      hi7_r <= hi6_r;
    end
    if (en[8]) begin
      hi8_r <= hi7_r;
    end
  end

  // stage 9: place levels by sector into the output register
  assign mid = mid_quo[CHAN_W-1:0];
  assign hi  = hi8_r;

  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (!flag_r[8]) begin
      case (sect_r[8])
        SECT_0: begin
          red_nxt   = hi;
          green_nxt = mid;
        end
        SECT_1: begin
          red_nxt   = mid;
          green_nxt = hi;
        end
        SECT_2: begin
          green_nxt = hi;
          blue_nxt  = mid;
        end
        SECT_3: begin
          green_nxt = mid;
          blue_nxt  = hi;
        end
        SECT_4: begin
          red_nxt  = mid;
          blue_nxt = hi;
        end
        default: begin
          red_nxt  = hi;
          blue_nxt = mid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      flag9_r <= flag_r[8];
    end
  end

  assign out_valid            = vld_r[STAGES];
  assign out_red              = red_r;
  assign out_green            = green_r;
  assign out_blue             = blue_r;
  assign out_hue_out_of_range = flag9_r;

endmodule

`default_nettype wire

/* hw/rtl/hsv2rgb_div10k.sv */
// two-stage divide by 10000: reciprocal estimate, then a single correction step
// depends on hsv2rgb_pkg for widths, reciprocal and the stage enable struct
`default_nettype none

module hsv2rgb_div10k (
  input  logic                             clk,
  input  hsv2rgb_pkg::div_en_t             en,
  input  logic [hsv2rgb_pkg::NUM_W-1:0]    num,
  output logic [hsv2rgb_pkg::QUO_W-1:0]    quo
);
  import hsv2rgb_pkg::*;

  logic [DIV_N_W-1:0]         n;
  logic [DIV_N_W+RECIP_W-1:0] prod;
  logic [QUO_W-1:0]           q_est_nxt;
  logic [DIV_N_W-1:0]         n_r;
  logic [QUO_W-1:0]           q_est_r;
  logic [DIV_N_W-1:0]         back;
  logic [DIV_N_W-1:0]         rem;
  logic [QUO_W-1:0]           quo_nxt;
  logic [QUO_W-1:0]           quo_r;

  // estimate stage: low by at most one
  assign n = num[NUM_W-1:DIV_PRE_SHIFT];
  assign prod = (DIV_N_W+RECIP_W)'(n) * (DIV_N_W+RECIP_W)'(RECIP);
  assign q_est_nxt = prod[RECIP_SHIFT +: QUO_W];

  always_ff @(posedge clk) begin
    if (en.est) begin
      n_r     <= n;
      q_est_r <= q_est_nxt;
    end
  end

  // correction stage: bump the quotient when the remainder reaches the divisor
  assign back = DIV_N_W'(q_est_r) * DIV_N_W'(DIV_D);
  assign rem = n_r - back;
  assign quo_nxt = (rem >= DIV_N_W'(DIV_D)) ? q_est_r + QUO_W'(1) : q_est_r;

  always_ff @(posedge clk) begin
    if (en.fix) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

`default_nettype wire
